[src/isk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package isk_pkg;

  localparam int MAX_NAME_DEF = 8;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 5;
  localparam int LEN_W        = 4;
  localparam int FIFO_DEPTH   = 4;

  localparam logic [1:0] REG_SECTION_NAME   = 2'd0;
  localparam logic [1:0] REG_SECTION_LENGTH = 2'd1;
  localparam logic [1:0] REG_KEY_NAME       = 2'd2;
  localparam logic [1:0] REG_KEY_LENGTH     = 2'd3;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_RBR  = 8'h5D;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_SP   = 8'h20;

  typedef struct packed {
    logic [63:0]      section_name;
    logic [LEN_W-1:0] section_length;
    logic [63:0]      key_name;
    logic [LEN_W-1:0] key_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       answer_end;
    logic       key_found;
  } result_t;

  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } emit_t;

endpackage

`default_nettype wire

[src/isk_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface isk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface isk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       answer_end;
  logic       key_found;

  modport source (output valid, output value_byte, output answer_end, output key_found,
                  input ready);
  modport sink   (input valid, input value_byte, input answer_end, input key_found,
                  output ready);
endinterface

`default_nettype wire

[src/ini_section_key_lookup_core.sv]
// INI section/key lookup.
// in_bus carries the text one word (byte plus final flag) per cycle while it is
// ready; out_bus returns value bytes of the matching key, then one terminator word
// whose key_found flag tells whether the key was seen. A final or NUL byte ends the
// text; a final byte also restarts the parser for the next text.
// Section and key names are written over the cfg_ port (64-bit registers at
// byte addresses 0, 8, 16, 24); the user must write them only while the block
// is idle, as the block does not enforce this. pready is always high.
// Throughput: one input word per cycle while in_bus.ready is high. A result
// passes the input register, then the parse logic writes it into the 4-entry
// result queue, from which out_bus presents it.
// A word that yields two results (value byte plus terminator) writes both
// queue entries at once; the queue absorbs it while input keeps flowing.
// When out_bus stalls, the queue fills and in_bus.ready drops while a word
// waits in the input register and fewer than two queue entries are free;
// nothing is lost.
// Reset (rst_n low, synchronous) clears registers, parse state and queue.
`timescale 1ns / 1ps
`default_nettype none

module ini_section_key_lookup_core #(
  parameter int MAX_NAME = isk_pkg::MAX_NAME_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  isk_in_if.sink                              in_bus,
  isk_out_if.source                           out_bus,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [isk_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [isk_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [isk_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                cfg_pready
);

  isk_pkg::cfg_t  cfg;
  isk_pkg::emit_t em;
  logic           in_valid_r;
  logic [7:0]     in_text_r;
  logic           in_final_r;
  logic           room;
  logic           step;

  assign step         = in_valid_r && room;
  assign in_bus.ready = !in_valid_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      in_text_r  <= in_bus.text_byte;
      in_final_r <= in_bus.final_byte;
    end
  end

  isk_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  isk_parser #(
    .MAX_NAME (MAX_NAME)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .text_byte  (in_text_r),
    .final_byte (in_final_r),
    .cfg        (cfg),
    .em         (em)
  );

  isk_out_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .em      (em),
    .room    (room),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire

[src/isk_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module isk_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [isk_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [isk_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [isk_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                cfg_pready,
  output isk_pkg::cfg_t                       cfg
);

  isk_pkg::cfg_t cfg_r;
  logic [1:0]    idx;
  logic          wr_en;

  assign idx        = cfg_paddr[4:3];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        isk_pkg::REG_SECTION_NAME:   cfg_r.section_name   <= cfg_pwdata;
        isk_pkg::REG_SECTION_LENGTH: cfg_r.section_length <= cfg_pwdata[isk_pkg::LEN_W-1:0];
        isk_pkg::REG_KEY_NAME:       cfg_r.key_name       <= cfg_pwdata;
        isk_pkg::REG_KEY_LENGTH:     cfg_r.key_length     <= cfg_pwdata[isk_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      isk_pkg::REG_SECTION_NAME:   cfg_prdata = cfg_r.section_name;
      isk_pkg::REG_SECTION_LENGTH: cfg_prdata = {{(isk_pkg::CFG_DATA_W-isk_pkg::LEN_W){1'b0}},
                                                 cfg_r.section_length};
      isk_pkg::REG_KEY_NAME:       cfg_prdata = cfg_r.key_name;
      isk_pkg::REG_KEY_LENGTH:     cfg_prdata = {{(isk_pkg::CFG_DATA_W-isk_pkg::LEN_W){1'b0}},
                                                 cfg_r.key_length};
      default:                     cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[src/isk_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module isk_parser #(
  parameter int MAX_NAME = isk_pkg::MAX_NAME_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    text_byte,
  input  wire logic          final_byte,
  input  isk_pkg::cfg_t      cfg,
  output isk_pkg::emit_t     em
);

  localparam int TW = 8 * MAX_NAME;
  localparam int CW = $clog2(MAX_NAME + 2);

  localparam logic [2:0] PH_SEEK   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_BODY   = 3'd2;
  localparam logic [2:0] PH_VALUE  = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  logic [2:0]    phase_r, phase_nxt;
  logic [TW-1:0] hdr_text_r, hdr_text_nxt, line_text_r, line_text_nxt;
  logic [CW-1:0] hdr_cnt_r, hdr_cnt_nxt, line_cnt_r, line_cnt_nxt;

  logic [TW-1:0] hdr_app_text, line_app_text;
  logic [CW-1:0] hdr_app_cnt, line_app_cnt;
  logic          hdr_match, line_match;
  logic          is_nul, is_drop, proceed;

  // append the byte at the fill position, saturate past MAX_NAME
  always_comb begin
    hdr_app_text  = hdr_text_r;
    line_app_text = line_text_r;
    for (int i = 0; i < MAX_NAME; i++) begin
      if (hdr_cnt_r == CW'(i)) hdr_app_text[8*i +: 8] = text_byte;
      if (line_cnt_r == CW'(i)) line_app_text[8*i +: 8] = text_byte;
    end
    hdr_app_cnt  = (hdr_cnt_r < CW'(MAX_NAME)) ? hdr_cnt_r + CW'(1) : CW'(MAX_NAME + 1);
    line_app_cnt = (line_cnt_r < CW'(MAX_NAME)) ? line_cnt_r + CW'(1) : CW'(MAX_NAME + 1);
  end

  always_comb begin
    hdr_match  = (hdr_cnt_r <= CW'(MAX_NAME)) &&
                 (isk_pkg::LEN_W'(hdr_cnt_r) == cfg.section_length);
    line_match = (line_cnt_r <= CW'(MAX_NAME)) &&
                 (isk_pkg::LEN_W'(line_cnt_r) == cfg.key_length);
    for (int i = 0; i < MAX_NAME; i++) begin
      if (CW'(i) < hdr_cnt_r && hdr_text_r[8*i +: 8] != cfg.section_name[8*i +: 8])
        hdr_match = 1'b0;
      if (CW'(i) < line_cnt_r && line_text_r[8*i +: 8] != cfg.key_name[8*i +: 8])
        line_match = 1'b0;
    end
  end

  assign is_nul  = (text_byte == isk_pkg::CH_NUL);
  assign is_drop = (text_byte == isk_pkg::CH_SP) || (text_byte == isk_pkg::CH_TAB) ||
                   (text_byte == isk_pkg::CH_VT) || (text_byte == isk_pkg::CH_FF) ||
                   (text_byte == isk_pkg::CH_BS);
  assign proceed = !is_nul && !is_drop && (phase_r != PH_DONE);

  always_comb begin
    isk_pkg::result_t res_a;
    isk_pkg::result_t res_b;
    logic             has_a;
    logic             has_b;
    res_a         = '0;
    res_b         = '0;
    has_a         = 1'b0;
    has_b         = 1'b0;
    phase_nxt     = phase_r;
    hdr_text_nxt  = hdr_text_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    line_text_nxt = line_text_r;
    line_cnt_nxt  = line_cnt_r;

    if (proceed) begin
      unique case (phase_r)
        PH_SEEK: begin
          if (text_byte == isk_pkg::CH_LBR) begin
            phase_nxt    = PH_HEADER;
            hdr_text_nxt = '0;
            hdr_cnt_nxt  = '0;
          end
        end
        PH_HEADER: begin
          if (text_byte == isk_pkg::CH_RBR) begin
            phase_nxt = hdr_match ? PH_BODY : PH_SEEK;
          end else begin
            hdr_text_nxt = hdr_app_text;
            hdr_cnt_nxt  = hdr_app_cnt;
          end
        end
        PH_BODY: begin
          if (text_byte == isk_pkg::CH_LBR) begin
            has_a            = 1'b1;
            res_a.answer_end = 1'b1;
            phase_nxt        = PH_DONE;
          end else if (text_byte == isk_pkg::CH_EQ && line_match) begin
            phase_nxt = PH_VALUE;
          end
        end
        PH_VALUE: begin
          has_a = 1'b1;
          if (text_byte == isk_pkg::CH_NL) begin
            res_a.answer_end = 1'b1;
            res_a.key_found  = 1'b1;
            phase_nxt        = PH_DONE;
          end else begin
            res_a.value_byte = text_byte;
          end
        end
        default: ;
      endcase
      if (text_byte == isk_pkg::CH_NL) begin
        line_text_nxt = '0;
        line_cnt_nxt  = '0;
      end else begin
        line_text_nxt = line_app_text;
        line_cnt_nxt  = line_app_cnt;
      end
    end

    if (final_byte || is_nul) begin
      if (phase_nxt != PH_DONE) begin
        res_b.answer_end = 1'b1;
        res_b.key_found  = (phase_nxt == PH_VALUE);
        has_b            = 1'b1;
      end
      if (final_byte) begin
        phase_nxt     = PH_SEEK;
        hdr_text_nxt  = '0;
        hdr_cnt_nxt   = '0;
        line_text_nxt = '0;
        line_cnt_nxt  = '0;
      end else begin
        phase_nxt = PH_DONE;
      end
    end

    // pack so that the first result always sits in slot 0
    em.v0 = step && (has_a || has_b);
    em.v1 = step && has_a && has_b;
    em.r0 = has_a ? res_a : res_b;
    em.r1 = res_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEEK;
      hdr_text_r  <= '0;
      hdr_cnt_r   <= '0;
      line_text_r <= '0;
      line_cnt_r  <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      hdr_text_r  <= hdr_text_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      line_text_r <= line_text_nxt;
      line_cnt_r  <= line_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[src/isk_out_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module isk_out_fifo (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  isk_pkg::emit_t em,
  output logic          room,
  isk_out_if.source     out_bus
);

  localparam int DEPTH = isk_pkg::FIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  isk_pkg::result_t mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;
  logic             pop;
  logic [1:0]       push_n;

  assign pop    = out_bus.valid && out_bus.ready;
  assign push_n = {1'b0, em.v0} + {1'b0, em.v1};
  assign room   = (cnt_r <= NW'(DEPTH - 2));

  assign out_bus.valid      = (cnt_r != '0);
  assign out_bus.value_byte = mem_r[rp_r].value_byte;
  assign out_bus.answer_end = mem_r[rp_r].answer_end;
  assign out_bus.key_found  = mem_r[rp_r].key_found;

  always_comb begin
    wp_nxt  = wp_r + PW'(push_n);
    rp_nxt  = rp_r + PW'(pop);
    cnt_nxt = cnt_r + NW'(push_n) - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (em.v0) mem_r[wp_r] <= em.r0;
    if (em.v1) mem_r[wp_r + PW'(1)] <= em.r1;
  end

endmodule

`default_nettype wire

[src/isk_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module isk_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_value_byte,
  input wire logic       out_answer_end,
  input wire logic       out_key_found,
  input wire logic       cfg_pready
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("cfg pready low");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_byte) &&
    $stable(out_answer_end) && $stable(out_key_found))
    else $error("stalled result word changed");

  a_word_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_answer_end && out_value_byte == 8'h00) ||
                  (!out_answer_end && !out_key_found && out_value_byte != 8'h00))
    else $error("malformed result word");

endmodule

bind ini_section_key_lookup_core isk_checker u_isk_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_value_byte (out_bus.value_byte),
  .out_answer_end (out_bus.answer_end),
  .out_key_found  (out_bus.key_found),
  .cfg_pready     (cfg_pready)
);

`default_nettype wire

[sim/ini_section_key_lookup_core_tb.sv]
`timescale 1ns / 1ps

module ini_section_key_lookup_core_tb;
  import isk_pkg::*;

  localparam int NAME_MAX = MAX_NAME_DEF;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_A  = 8'h61;

  typedef enum logic [2:0] {
    SEEK_HEADER, IN_HEADER, IN_BODY, IN_VALUE, ANSWERED
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } text_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  isk_in_if  in_bus ();
  isk_out_if out_bus ();

  ini_section_key_lookup_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  text_word_t word_q[$];
  logic [7:0] text_buf[$];
  result_t    answer_q[$];
  text_word_t next_word;
  result_t    want_answer;
  bit         in_taken;
  int         send_gap_pct;
  int         recv_stall_pct;
  int         queued_words;
  int         err_count;

  // lookup registers as written, and parser state
  logic [63:0]      section_reg;
  logic [LEN_W-1:0] section_len_reg;
  logic [63:0]      key_reg;
  logic [LEN_W-1:0] key_len_reg;
  parse_phase_e     parse_phase;
  logic [63:0]      hdr_text;
  logic [3:0]       hdr_count;
  logic [63:0]      line_text;
  logic [3:0]       line_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("ini_section_key_lookup_core_tb failed");
    $finish;
  end

  function automatic bit name_match(input logic [63:0] txt, input logic [3:0] cnt,
                                    input logic [63:0] nm, input logic [3:0] len);
    logic [63:0] mask;
    if (cnt > NAME_MAX || cnt != len) return 1'b0;
    mask = (cnt >= 8) ? '1 : ((64'd1 << (8 * cnt)) - 64'd1);
    return ((txt ^ nm) & mask) == 64'd0;
  endfunction

  task automatic add_char(inout logic [63:0] txt, inout logic [3:0] cnt,
                          input logic [7:0] b);
    if (cnt < NAME_MAX) begin
      txt = txt | (64'(b) << (8 * cnt));
      cnt = cnt + 4'd1;
    end else begin
      cnt = 4'(NAME_MAX + 1);
    end
  endtask

  task automatic note_answer(input logic [7:0] b, input logic last, input logic found);
    result_t r;
    r.value_byte = b;
    r.answer_end = last;
    r.key_found  = found;
    answer_q.push_back(r);
  endtask

  task automatic clear_parser();
    parse_phase = SEEK_HEADER;
    hdr_text    = '0;
    hdr_count   = '0;
    line_text   = '0;
    line_count  = '0;
  endtask

  task automatic predict_word(input logic [7:0] b, input logic fin);
    bit skip;
    skip = (b == CH_NUL) || (b == CH_SP) || (b == CH_TAB) || (b == CH_VT) ||
           (b == CH_FF) || (b == CH_BS) || (parse_phase == ANSWERED);
    if (!skip) begin
      case (parse_phase)
        SEEK_HEADER: begin
          if (b == CH_LBR) begin
            parse_phase = IN_HEADER;
            hdr_text    = '0;
            hdr_count   = '0;
          end
        end
        IN_HEADER: begin
          if (b == CH_RBR)
            parse_phase = name_match(hdr_text, hdr_count, section_reg, section_len_reg) ?
                          IN_BODY : SEEK_HEADER;
          else
            add_char(hdr_text, hdr_count, b);
        end
        IN_BODY: begin
          if (b == CH_LBR) begin
            note_answer(8'h00, 1'b1, 1'b0);
            parse_phase = ANSWERED;
          end else if (b == CH_EQ &&
                       name_match(line_text, line_count, key_reg, key_len_reg)) begin
            parse_phase = IN_VALUE;
          end
        end
        default: begin
          if (b == CH_NL) begin
            note_answer(8'h00, 1'b1, 1'b1);
            parse_phase = ANSWERED;
          end else begin
            note_answer(b, 1'b0, 1'b0);
          end
        end
      endcase
      if (b == CH_NL) begin
        line_text  = '0;
        line_count = '0;
      end else begin
        add_char(line_text, line_count, b);
      end
    end
    if (fin || b == CH_NUL) begin
      if (parse_phase != ANSWERED) note_answer(8'h00, 1'b1, parse_phase == IN_VALUE);
      if (fin) clear_parser();
      else parse_phase = ANSWERED;
    end
  endtask

  // accepted words feed the predictor; results are checked in order
  always @(posedge clk) begin
    in_taken = rst_n && in_bus.valid && in_bus.ready;
    if (in_taken) predict_word(in_bus.text_byte, in_bus.final_byte);
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result: value_byte %h answer_end %b key_found %b",
                 $time, out_bus.value_byte, out_bus.answer_end, out_bus.key_found);
        err_count++;
      end else begin
        want_answer = answer_q.pop_front();
        if (out_bus.value_byte !== want_answer.value_byte) begin
          $display("%0t: value_byte expected %h actual %h",
                   $time, want_answer.value_byte, out_bus.value_byte);
          err_count++;
        end
        if (out_bus.answer_end !== want_answer.answer_end) begin
          $display("%0t: answer_end expected %b actual %b",
                   $time, want_answer.answer_end, out_bus.answer_end);
          err_count++;
        end
        if (out_bus.key_found !== want_answer.key_found) begin
          $display("%0t: key_found expected %b actual %b",
                   $time, want_answer.key_found, out_bus.key_found);
          err_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_word = word_q.pop_front();
        in_bus.valid      <= 1'b1;
        in_bus.text_byte  <= next_word.text_byte;
        in_bus.final_byte <= next_word.final_byte;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
    out_bus.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_SECTION_NAME:   section_reg     = val;
      REG_SECTION_LENGTH: section_len_reg = val[LEN_W-1:0];
      REG_KEY_NAME:       key_reg         = val;
      default:            key_len_reg     = val[LEN_W-1:0];
    endcase
  endtask

  task automatic set_lookup(input logic [63:0] sec, input logic [3:0] sec_len,
                            input logic [63:0] key, input logic [3:0] k_len);
    write_reg(REG_SECTION_NAME, sec);
    write_reg(REG_SECTION_LENGTH, 64'(sec_len));
    write_reg(REG_KEY_NAME, key);
    write_reg(REG_KEY_LENGTH, 64'(k_len));
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (!(word_q.size() == 0 && !in_bus.valid && answer_q.size() == 0))
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic push_word(input logic [7:0] b, input logic fin);
    text_word_t w;
    w.text_byte  = b;
    w.final_byte = fin;
    word_q.push_back(w);
    queued_words++;
  endtask

  task automatic push_str(input string s, input bit fin_last);
    for (int i = 0; i < s.len(); i++)
      push_word(s[i], fin_last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_letter();
    return CH_A + 8'($urandom_range(25));
  endfunction

  function automatic logic [63:0] rand_name();
    logic [63:0] n;
    for (int i = 0; i < 8; i++) n[8*i +: 8] = rand_letter();
    return n;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(4))
      0:       return CH_SP;
      1:       return CH_TAB;
      2:       return CH_VT;
      3:       return CH_FF;
      default: return CH_BS;
    endcase
  endfunction

  function automatic logic [7:0] value_char();
    case ($urandom_range(9))
      0:       return CH_CR;
      1:       return 8'($urandom_range(128, 255));
      2:       return CH_EQ;
      default: return rand_letter();
    endcase
  endfunction

  task automatic put_name(input logic [63:0] nm, input logic [3:0] len);
    for (int i = 0; i < len && i < NAME_MAX; i++) begin
      if ($urandom_range(5) == 0) text_buf.push_back(blank_char());
      text_buf.push_back(nm[8*i +: 8]);
    end
  endtask

  task automatic put_random_name(input int n);
    for (int i = 0; i < n; i++) text_buf.push_back(rand_letter());
  endtask

  task automatic put_header(input bit target);
    text_buf.push_back(CH_LBR);
    if (target) put_name(section_reg, section_len_reg);
    else put_random_name($urandom_range(0, 10));
    if ($urandom_range(9) != 0) text_buf.push_back(CH_RBR);
    if ($urandom_range(3) != 0) text_buf.push_back(CH_NL);
  endtask

  // one ini text: headers, key lines, noise; last word carries final_byte
  task automatic gen_text(input int budget);
    int n;
    text_buf.delete();
    if ($urandom_range(3) != 0) put_header(1'b1);
    while (text_buf.size() < budget) begin
      case ($urandom_range(9))
        0, 1: put_header($urandom_range(1));
        2, 3, 4, 5: begin
          if ($urandom_range(1)) put_name(key_reg, key_len_reg);
          else put_random_name($urandom_range(0, 10));
          if ($urandom_range(3) == 0) text_buf.push_back(blank_char());
          text_buf.push_back(CH_EQ);
          n = $urandom_range(0, 5);
          for (int i = 0; i < n; i++) text_buf.push_back(value_char());
          if ($urandom_range(7) != 0) text_buf.push_back(CH_NL);
        end
        6: begin
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) text_buf.push_back(8'($urandom_range(255)));
        end
        7: text_buf.push_back(blank_char());
        8: text_buf.push_back(value_char());
        default: text_buf.push_back(CH_NL);
      endcase
    end
    case ($urandom_range(7))
      0: begin
        text_buf.push_back(CH_NUL);
        text_buf.push_back(8'($urandom_range(255)));
      end
      1: text_buf.push_back(CH_NUL);
      2: text_buf.push_back(CH_NL);
      default: ;
    endcase
    for (int i = 0; i < text_buf.size(); i++)
      push_word(text_buf[i], i == text_buf.size() - 1);
  endtask

  initial begin
    bit held;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.text_byte  = '0;
    in_bus.final_byte = 1'b0;
    out_bus.ready     = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    err_count         = 0;
    queued_words      = 0;
    held              = 1'b0;
    section_reg       = '0;
    section_len_reg   = '0;
    key_reg           = '0;
    key_len_reg       = '0;
    clear_parser();
    send_gap_pct      = 7;
    recv_stall_pct    = 72;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: match with final on a value byte, '[' in body, NUL, blanks only
    set_lookup(64'h636261, 4'd3, 64'h6B, 4'd1);
    push_str("[abc]\nk=x", 1'b1);
    push_str("[abc]\n[", 1'b1);
    push_word(CH_NUL, 1'b0);
    push_word(8'h7A, 1'b1);
    push_word(CH_TAB, 1'b0);
    push_word(CH_VT, 1'b0);
    push_word(CH_FF, 1'b0);
    push_word(CH_BS, 1'b0);
    push_word(CH_SP, 1'b0);
    push_word(8'hFF, 1'b1);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        send_gap_pct   = 7;
        recv_stall_pct = 72;
      end else if (p < 4) begin
        send_gap_pct   = 72;
        recv_stall_pct = 7;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      case (p)
        0: set_lookup(rand_name(), 4'($urandom_range(1, 4)),
                      rand_name(), 4'($urandom_range(1, 4)));
        1: set_lookup(rand_name(), 4'd8, rand_name(), 4'd8);
        2: set_lookup('0, 4'd0, '0, 4'd0);
        3: set_lookup('1, 4'd8, '1, 4'd8);
        4: set_lookup(rand_name(), 4'd15, rand_name(), 4'($urandom_range(1, 3)));
        default: set_lookup(rand_name(), 4'($urandom_range(1, 3)), rand_name(), 4'd12);
      endcase
      queued_words = 0;
      while (queued_words < 80) begin
        gen_text($urandom_range(12, 40));
        // hold the sender until the block has drained
        if (p == 0 && !held && queued_words >= 40) begin
          wait_drained();
          held = 1'b1;
        end
      end
      wait_drained();
    end

    if (err_count == 0)
      $display("ini_section_key_lookup_core_tb passed");
    else
      $display("ini_section_key_lookup_core_tb failed");
    $finish;
  end

endmodule
